// ===== rtl/dma4_pkg.sv =====
package dma4_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int ADDR_BITS    = 24;

    localparam int CH_SLOTS     = 4;
    localparam int CH_W         = 2;
    localparam int XFER_ADDR_W  = 24;
    localparam int IN_W         = 24;
    localparam int OUT_W        = 56;

    localparam logic [7:0] MODE_RESET = 8'h04;
    localparam logic [7:0] MASK_RESET = 8'h0f;
    localparam logic [7:0] UNMAPPED   = 8'hff;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_REQ   = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_VERIFY = 2'd0,
        KIND_IO2MEM = 2'd1,
        KIND_MEM2IO = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    localparam logic [3:0] REG_CTRL    = 4'h0;
    localparam logic [3:0] REG_SELECT  = 4'h1;
    localparam logic [3:0] REG_CNT_LO  = 4'h2;
    localparam logic [3:0] REG_CNT_HI  = 4'h3;
    localparam logic [3:0] REG_ADDR_0  = 4'h4;
    localparam logic [3:0] REG_ADDR_1  = 4'h5;
    localparam logic [3:0] REG_ADDR_2  = 4'h6;
    localparam logic [3:0] REG_CMD_LO  = 4'h8;
    localparam logic [3:0] REG_CMD_HI  = 4'h9;
    localparam logic [3:0] REG_MODE    = 4'ha;
    localparam logic [3:0] REG_STATUS  = 4'hb;
    localparam logic [3:0] REG_TEMP_LO = 4'hc;
    localparam logic [3:0] REG_TEMP_HI = 4'hd;
    localparam logic [3:0] REG_SWREQ   = 4'he;
    localparam logic [3:0] REG_MASK    = 4'hf;

    // packed from the top bit down; the first field sits in the high bits, the last in the low bits
    typedef struct packed {
        logic       pad;
        logic [7:0] transfer_byte;
        logic       request_level;
        logic [1:0] req_channel;
        logic [7:0] write_data;
        logic [3:0] reg_addr;
    } in_item_t;

    typedef struct packed {
        logic [5:0]             pad;
        logic                   tc_pulse;
        logic [3:0]             extra_clocks;
        logic [7:0]             xfer_byte;
        logic [1:0]             xfer_kind;
        logic [XFER_ADDR_W-1:0] xfer_address;
        logic [CH_W-1:0]        xfer_channel;
        logic                   transfer_valid;
        logic [7:0]             read_data;
    } res_t;

endpackage

// ===== rtl/four_channel_dma_controller.sv =====
// Four-channel DMA controller, 15 byte-wide registers at 16 addresses. Each
// input item is a register write, a register read, a request line change or
// a transfer tick (tuser); each gives exactly one result item. An item is
// registered on entry, worked in combinational logic against the register
// file and the result is registered, so one item is taken every clock;
// throughput stalls only when the result output is held by tready. A tick
// serves the lowest-numbered unmasked channel with a hardware or software
// request, unless DMA is disabled by command bit 2. Reading the status
// register clears the terminal-count flags.
module four_channel_dma_controller
    import dma4_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // reg_addr, write_data, req_channel, request_level, transfer_byte
    input  logic [IN_W-1:0]  s_axis_tdata,
    // command
    input  logic [1:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // read_data, transfer_valid, xfer_channel, xfer_address, xfer_kind,
    // xfer_byte, extra_clocks, tc_pulse
    output logic [OUT_W-1:0] m_axis_tdata
);

    logic                 in_valid_reg, in_valid_next;
    in_item_t             in_item_reg;
    cmd_t                 in_cmd_reg;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_data_reg, out_data_next;

    logic [ADDR_BITS-1:0] base_addr_reg [CH_SLOTS];
    logic [ADDR_BITS-1:0] base_addr_next [CH_SLOTS];
    logic [ADDR_BITS-1:0] cur_addr_reg [CH_SLOTS];
    logic [ADDR_BITS-1:0] cur_addr_next [CH_SLOTS];
    logic [15:0]          base_cnt_reg [CH_SLOTS];
    logic [15:0]          base_cnt_next [CH_SLOTS];
    logic [15:0]          cur_cnt_reg [CH_SLOTS];
    logic [15:0]          cur_cnt_next [CH_SLOTS];
    logic [7:0]           mode_reg [CH_SLOTS];
    logic [7:0]           mode_next [CH_SLOTS];
    logic [15:0]          cmd_word_reg, cmd_word_next;
    logic [15:0]          temp_reg, temp_next;
    logic [3:0]           hw_req_reg, hw_req_next;
    logic [7:0]           sw_req_reg, sw_req_next;
    logic [7:0]           mask_reg, mask_next;
    logic [3:0]           tc_reg, tc_next;
    logic [CH_W-1:0]      sel_reg, sel_next;
    logic                 base_only_reg, base_only_next;
    logic                 wide_reg, wide_next;
    logic                 busy_reg, busy_next;

    logic                 s_accept;
    logic                 process;

    assign process       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || process;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        logic [3:0]           pend;
        logic                 found;
        logic [CH_W-1:0]      found_ch;
        logic [CH_W-1:0]      idx;
        logic [ADDR_BITS-1:0] ca;
        logic [ADDR_BITS-1:0] ba;
        logic [15:0]          cc;
        logic [15:0]          bc;
        logic [7:0]           md;
        logic [31:0]          aw;
        logic [15:0]          cv;
        logic [7:0]           bit8;
        logic [3:0]           wait_clk;

        in_valid_next  = s_accept ? 1'b1 : (process ? 1'b0 : in_valid_reg);
        out_valid_next = process ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
        out_data_next  = out_data_reg;

        base_addr_next = base_addr_reg;
        cur_addr_next  = cur_addr_reg;
        base_cnt_next  = base_cnt_reg;
        cur_cnt_next   = cur_cnt_reg;
        mode_next      = mode_reg;
        cmd_word_next  = cmd_word_reg;
        temp_next      = temp_reg;
        hw_req_next    = hw_req_reg;
        sw_req_next    = sw_req_reg;
        mask_next      = mask_reg;
        tc_next        = tc_reg;
        sel_next       = sel_reg;
        base_only_next = base_only_reg;
        wide_next      = wide_reg;
        busy_next      = busy_reg;

        pend     = (hw_req_reg | sw_req_reg[3:0]) & ~mask_reg[3:0];
        found    = 1'b0;
        found_ch = '0;
        for (int c = NUM_CHANNELS - 1; c >= 0; c--)
        begin
            if (pend[c])
            begin
                found    = 1'b1;
                found_ch = CH_W'(c);
            end
        end

        idx = (in_cmd_reg == CMD_TICK) ? found_ch : sel_reg;
        ca  = cur_addr_reg[idx];
        ba  = base_addr_reg[idx];
        cc  = cur_cnt_reg[idx];
        bc  = base_cnt_reg[idx];
        md  = mode_reg[idx];
        aw  = 32'(base_only_reg ? ba : ca);
        cv  = base_only_reg ? bc : cc;
        bit8 = 8'(1) << idx;
        wait_clk = '0;

        if (process)
        begin
            out_data_next = '0;
            unique case (in_cmd_reg)
                CMD_WRITE:
                begin
                    unique case (in_item_reg.reg_addr)
                        REG_CTRL:
                        begin
                            if (in_item_reg.write_data[0])
                            begin
                                for (int i = 0; i < CH_SLOTS; i++)
                                begin
                                    mode_next[i] = MODE_RESET;
                                end
                                sel_next       = '0;
                                base_only_next = 1'b0;
                                cmd_word_next  = '0;
                                temp_next      = '0;
                                sw_req_next    = '0;
                                tc_next        = '0;
                                mask_next      = MASK_RESET;
                            end
                            wide_next = in_item_reg.write_data[1];
                        end
                        REG_SELECT:
                        begin
                            sel_next       = in_item_reg.write_data[CH_W-1:0];
                            base_only_next = in_item_reg.write_data[2];
                        end
                        REG_CNT_LO, REG_CNT_HI:
                        begin
                            if (in_item_reg.reg_addr[0])
                            begin
                                base_cnt_next[idx] = {in_item_reg.write_data, bc[7:0]};
                                cur_cnt_next[idx]  = {in_item_reg.write_data, cc[7:0]};
                            end
                            else
                            begin
                                base_cnt_next[idx] = {bc[15:8], in_item_reg.write_data};
                                cur_cnt_next[idx]  = {cc[15:8], in_item_reg.write_data};
                            end
                        end
                        REG_ADDR_0, REG_ADDR_1, REG_ADDR_2:
                        begin
                            logic [31:0] bw;
                            logic [31:0] cw;
                            bw = 32'(ba);
                            cw = 32'(ca);
                            unique case (in_item_reg.reg_addr)
                                REG_ADDR_0:
                                begin
                                    bw[7:0] = in_item_reg.write_data;
                                    cw[7:0] = in_item_reg.write_data;
                                end
                                REG_ADDR_1:
                                begin
                                    bw[15:8] = in_item_reg.write_data;
                                    cw[15:8] = in_item_reg.write_data;
                                end
                                default:
                                begin
                                    bw[23:16] = in_item_reg.write_data;
                                    cw[23:16] = in_item_reg.write_data;
                                end
                            endcase
                            base_addr_next[idx] = ADDR_BITS'(bw);
                            cur_addr_next[idx]  = ADDR_BITS'(cw);
                        end
                        REG_CMD_LO: cmd_word_next[7:0]  = in_item_reg.write_data;
                        REG_CMD_HI: cmd_word_next[15:8] = in_item_reg.write_data;
                        REG_MODE:   mode_next[idx]      = in_item_reg.write_data;
                        REG_SWREQ:  sw_req_next         = in_item_reg.write_data;
                        REG_MASK:   mask_next           = in_item_reg.write_data;
                        default:    ;
                    endcase
                end
                CMD_READ:
                begin
                    unique case (in_item_reg.reg_addr)
                        REG_CTRL:    out_data_next.read_data = {6'd0, wide_reg, 1'b0};
                        REG_SELECT:
                            out_data_next.read_data = {5'd0, base_only_reg, 2'd0} | bit8;
                        REG_CNT_LO:  out_data_next.read_data = cv[7:0];
                        REG_CNT_HI:  out_data_next.read_data = cv[15:8];
                        REG_ADDR_0:  out_data_next.read_data = aw[7:0];
                        REG_ADDR_1:  out_data_next.read_data = aw[15:8];
                        REG_ADDR_2:  out_data_next.read_data = aw[23:16];
                        REG_CMD_LO:  out_data_next.read_data = cmd_word_reg[7:0];
                        REG_CMD_HI:  out_data_next.read_data = cmd_word_reg[15:8];
                        REG_MODE:    out_data_next.read_data = md;
                        REG_STATUS:
                        begin
                            out_data_next.read_data = {hw_req_reg, tc_reg};
                            tc_next = '0;
                        end
                        REG_TEMP_LO: out_data_next.read_data = temp_reg[7:0];
                        REG_TEMP_HI: out_data_next.read_data = temp_reg[15:8];
                        REG_SWREQ:   out_data_next.read_data = sw_req_reg;
                        REG_MASK:    out_data_next.read_data = mask_reg;
                        default:     out_data_next.read_data = UNMAPPED;
                    endcase
                end
                CMD_REQ:
                begin
                    if (32'(in_item_reg.req_channel) < NUM_CHANNELS)
                    begin
                        hw_req_next[in_item_reg.req_channel] = in_item_reg.request_level;
                    end
                end
                CMD_TICK:
                begin
                    if (!cmd_word_reg[2] && found)
                    begin
                        out_data_next.transfer_valid = 1'b1;
                        out_data_next.xfer_channel   = idx;
                        out_data_next.xfer_address   = XFER_ADDR_W'(ca);
                        out_data_next.xfer_kind      = KIND_NONE;
                        if (!busy_reg)
                        begin
                            wait_clk = 4'd2;
                        end
                        busy_next = 1'b1;
                        if (!md[0])
                        begin
                            if (md[3:2] != KIND_NONE)
                            begin
                                out_data_next.xfer_kind = md[3:2];
                                out_data_next.xfer_byte = in_item_reg.transfer_byte;
                                wait_clk = wait_clk + (cmd_word_reg[3] ? 4'd5 : 4'd7);
                                temp_next = {in_item_reg.transfer_byte, temp_reg[15:8]};
                            end
                            cur_addr_next[idx] = md[5] ? ca - 1'b1 : ca + 1'b1;
                        end
                        out_data_next.extra_clocks = wait_clk;
                        if (cc == '0)
                        begin
                            if (md[4])
                            begin
                                cur_addr_next[idx] = ba;
                                cur_cnt_next[idx]  = bc;
                            end
                            else
                            begin
                                mask_next         = mask_reg | bit8;
                                cur_cnt_next[idx] = 16'hffff;
                            end
                            hw_req_next = hw_req_reg & ~bit8[3:0];
                            sw_req_next = sw_req_reg & ~bit8;
                            tc_next     = tc_reg | bit8[3:0];
                            busy_next   = 1'b0;
                            out_data_next.tc_pulse = 1'b1;
                        end
                        else
                        begin
                            cur_cnt_next[idx] = cc - 1'b1;
                            if (md[7:6] == 2'b01)
                            begin
                                busy_next = 1'b0;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CH_SLOTS; i++)
            begin
                base_addr_reg[i] <= '0;
                cur_addr_reg[i]  <= '0;
                base_cnt_reg[i]  <= '0;
                cur_cnt_reg[i]   <= '0;
                mode_reg[i]      <= MODE_RESET;
            end
            cmd_word_reg  <= '0;
            temp_reg      <= '0;
            hw_req_reg    <= '0;
            sw_req_reg    <= '0;
            mask_reg      <= MASK_RESET;
            tc_reg        <= '0;
            sel_reg       <= '0;
            base_only_reg <= 1'b0;
            wide_reg      <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            base_addr_reg <= base_addr_next;
            cur_addr_reg  <= cur_addr_next;
            base_cnt_reg  <= base_cnt_next;
            cur_cnt_reg   <= cur_cnt_next;
            mode_reg      <= mode_next;
            cmd_word_reg  <= cmd_word_next;
            temp_reg      <= temp_next;
            hw_req_reg    <= hw_req_next;
            sw_req_reg    <= sw_req_next;
            mask_reg      <= mask_next;
            tc_reg        <= tc_next;
            sel_reg       <= sel_next;
            base_only_reg <= base_only_next;
            wide_reg      <= wide_next;
            busy_reg      <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= in_item_t'(s_axis_tdata);
            in_cmd_reg  <= cmd_t'(s_axis_tuser);
        end
        out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.transfer_valid
        |-> out_data_reg.extra_clocks == '0 && !out_data_reg.tc_pulse
            && out_data_reg.xfer_kind == KIND_VERIFY)
        else $error("non-transfer item carries transfer fields");

    a_xfer_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.transfer_valid |-> out_data_reg.read_data == '0)
        else $error("transfer item carries read data");

    a_data_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.transfer_valid && out_data_reg.xfer_kind != KIND_NONE
        |-> out_data_reg.extra_clocks >= 4'd5)
        else $error("data moved without bus wait charge");

    a_tc_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        process && in_cmd_reg == CMD_TICK && out_data_next.tc_pulse
        |=> tc_reg[$past(out_data_next.xfer_channel)] && !busy_reg)
        else $error("terminal count did not set its flag");
`endif

endmodule

// ===== verif/four_channel_dma_controller_tb.sv =====
`timescale 1ns / 100ps

module four_channel_dma_controller_tb;
    import dma4_pkg::*;

    localparam logic [3:0] REG_GAP = 4'h7;
    localparam int DIR_ROWS    = 26;
    localparam int RAND_ITEMS  = 1750;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        cmd_t       op;
        logic [3:0] addr;
        logic [7:0] data;
        logic [1:0] ch;
        logic       lvl;
        logic [7:0] xb;
        logic       typed;
        logic [7:0] rd;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic [1:0]       s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    four_channel_dma_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // register file and controller state as the block should hold them
    logic [XFER_ADDR_W-1:0] dma_base_addr [NUM_CHANNELS];
    logic [XFER_ADDR_W-1:0] dma_cur_addr  [NUM_CHANNELS];
    logic [15:0]            dma_base_cnt  [NUM_CHANNELS];
    logic [15:0]            dma_cur_cnt   [NUM_CHANNELS];
    logic [7:0]             dma_mode      [NUM_CHANNELS];
    logic [15:0]            dma_cmd_word;
    logic [15:0]            dma_temp;
    logic [3:0]             dma_hw_req;
    logic [7:0]             dma_sw_req;
    logic [7:0]             dma_mask;
    logic [3:0]             dma_tc;
    logic [1:0]             dma_sel;
    logic                   dma_base_only;
    logic                   dma_wide;
    logic                   dma_busy;

    res_t dma_results_due [$];
    int   mismatches = 0;
    int   results_seen = 0;
    int   src_idle_pct;
    int   sink_idle_pct;
    bit   hold_off_wanted;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_READ,  REG_MASK,    8'h00, 2'd0, 1'b0, 8'h00, 1'b1, MASK_RESET},
        '{CMD_READ,  REG_MODE,    8'h00, 2'd0, 1'b0, 8'h00, 1'b1, MODE_RESET},
        '{CMD_READ,  REG_GAP,     8'h00, 2'd0, 1'b0, 8'h00, 1'b1, UNMAPPED},
        '{CMD_READ,  REG_SELECT,  8'h00, 2'd0, 1'b0, 8'h00, 1'b1, 8'h01},
        '{CMD_READ,  REG_STATUS,  8'h00, 2'd0, 1'b0, 8'h00, 1'b1, 8'h00},
        '{CMD_WRITE, REG_CTRL,    8'h02, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_READ,  REG_CTRL,    8'h00, 2'd0, 1'b0, 8'h00, 1'b1, 8'h02},
        '{CMD_WRITE, REG_SELECT,  8'h01, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_WRITE, REG_ADDR_0,  8'hff, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_WRITE, REG_ADDR_1,  8'hff, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_WRITE, REG_ADDR_2,  8'hff, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_WRITE, REG_CNT_LO,  8'h01, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_WRITE, REG_MODE,    8'h08, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_WRITE, REG_MASK,    8'h00, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_REQ,   REG_CTRL,    8'h00, 2'd1, 1'b1, 8'h00, 1'b0, 8'h00},
        '{CMD_TICK,  REG_CTRL,    8'h00, 2'd0, 1'b0, 8'hff, 1'b0, 8'h00},
        '{CMD_TICK,  REG_CTRL,    8'h00, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_READ,  REG_STATUS,  8'h00, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_READ,  REG_TEMP_HI, 8'h00, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_WRITE, REG_CMD_LO,  8'h04, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_WRITE, REG_SWREQ,   8'hff, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_TICK,  REG_CTRL,    8'h00, 2'd0, 1'b0, 8'h5a, 1'b0, 8'h00},
        '{CMD_WRITE, REG_CMD_LO,  8'h08, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_TICK,  REG_CTRL,    8'h00, 2'd0, 1'b0, 8'ha5, 1'b0, 8'h00},
        '{CMD_WRITE, REG_STATUS,  8'hff, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00},
        '{CMD_READ,  REG_STATUS,  8'h00, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void dma_soft_clear();
        int i;
        for (i = 0; i < NUM_CHANNELS; i++)
            dma_mode[i] = MODE_RESET;
        dma_sel       = '0;
        dma_base_only = 1'b0;
        dma_cmd_word  = '0;
        dma_temp      = '0;
        dma_sw_req    = '0;
        dma_tc        = '0;
        dma_mask      = MASK_RESET;
    endfunction

    function automatic res_t dma_step_result(cmd_t op, in_item_t it);
        res_t       r;
        logic [1:0] s;
        logic [1:0] ch;
        logic [7:0] md;
        logic       found;
        logic [3:0] waits;
        kind_t      kind;
        logic [7:0] xb;
        int         i;
        r = '0;
        s = dma_sel;
        ch = '0;
        found = 1'b0;
        case (op)
            CMD_WRITE:
            begin
                case (it.reg_addr)
                    REG_CTRL:
                    begin
                        if (it.write_data[0])
                            dma_soft_clear();
                        dma_wide = it.write_data[1];
                    end
                    REG_SELECT:
                    begin
                        dma_sel = it.write_data[1:0];
                        dma_base_only = it.write_data[2];
                    end
                    REG_CNT_LO:
                    begin
                        dma_base_cnt[s][7:0] = it.write_data;
                        dma_cur_cnt[s][7:0]  = it.write_data;
                    end
                    REG_CNT_HI:
                    begin
                        dma_base_cnt[s][15:8] = it.write_data;
                        dma_cur_cnt[s][15:8]  = it.write_data;
                    end
                    REG_ADDR_0:
                    begin
                        dma_base_addr[s][7:0] = it.write_data;
                        dma_cur_addr[s][7:0]  = it.write_data;
                    end
                    REG_ADDR_1:
                    begin
                        dma_base_addr[s][15:8] = it.write_data;
                        dma_cur_addr[s][15:8]  = it.write_data;
                    end
                    REG_ADDR_2:
                    begin
                        dma_base_addr[s][23:16] = it.write_data;
                        dma_cur_addr[s][23:16]  = it.write_data;
                    end
                    REG_CMD_LO: dma_cmd_word[7:0]  = it.write_data;
                    REG_CMD_HI: dma_cmd_word[15:8] = it.write_data;
                    REG_MODE:   dma_mode[s] = it.write_data;
                    REG_SWREQ:  dma_sw_req = it.write_data;
                    REG_MASK:   dma_mask = it.write_data;
                    default: ;
                endcase
            end
            CMD_READ:
            begin
                case (it.reg_addr)
                    REG_CTRL:    r.read_data = {6'b0, dma_wide, 1'b0};
                    REG_SELECT:  r.read_data = {5'b0, dma_base_only, 2'b0} | (8'd1 << s);
                    REG_CNT_LO:  r.read_data = dma_base_only ? dma_base_cnt[s][7:0]
                                                             : dma_cur_cnt[s][7:0];
                    REG_CNT_HI:  r.read_data = dma_base_only ? dma_base_cnt[s][15:8]
                                                             : dma_cur_cnt[s][15:8];
                    REG_ADDR_0:  r.read_data = dma_base_only ? dma_base_addr[s][7:0]
                                                             : dma_cur_addr[s][7:0];
                    REG_ADDR_1:  r.read_data = dma_base_only ? dma_base_addr[s][15:8]
                                                             : dma_cur_addr[s][15:8];
                    REG_ADDR_2:  r.read_data = dma_base_only ? dma_base_addr[s][23:16]
                                                             : dma_cur_addr[s][23:16];
                    REG_CMD_LO:  r.read_data = dma_cmd_word[7:0];
                    REG_CMD_HI:  r.read_data = dma_cmd_word[15:8];
                    REG_MODE:    r.read_data = dma_mode[s];
                    REG_STATUS:
                    begin
                        r.read_data = {dma_hw_req, dma_tc};
                        dma_tc = '0;
                    end
                    REG_TEMP_LO: r.read_data = dma_temp[7:0];
                    REG_TEMP_HI: r.read_data = dma_temp[15:8];
                    REG_SWREQ:   r.read_data = dma_sw_req;
                    REG_MASK:    r.read_data = dma_mask;
                    default:     r.read_data = UNMAPPED;
                endcase
            end
            CMD_REQ:
                dma_hw_req[it.req_channel] = it.request_level;
            default:
            begin
                if (!dma_cmd_word[2])
                begin
                    for (i = 0; i < NUM_CHANNELS; i++)
                        if (!found && (dma_hw_req[i] || dma_sw_req[i]) && !dma_mask[i])
                        begin
                            found = 1'b1;
                            ch = 2'(i);
                        end
                end
                if (found)
                begin
                    md = dma_mode[ch];
                    waits = '0;
                    kind = KIND_NONE;
                    xb = '0;
                    r.transfer_valid = 1'b1;
                    r.xfer_channel = ch;
                    r.xfer_address = dma_cur_addr[ch];
                    if (!dma_busy)
                    begin
                        waits = 4'd2;
                        dma_busy = 1'b1;
                    end
                    // mode bit 0 moves nothing and leaves the address alone
                    if (!md[0])
                    begin
                        if (md[3:2] != KIND_NONE)
                        begin
                            kind = kind_t'(md[3:2]);
                            xb = it.transfer_byte;
                            waits = waits + (dma_cmd_word[3] ? 4'd5 : 4'd7);
                            dma_temp = {xb, dma_temp[15:8]};
                        end
                        if (md[5])
                            dma_cur_addr[ch] = dma_cur_addr[ch] - 1'b1;
                        else
                            dma_cur_addr[ch] = dma_cur_addr[ch] + 1'b1;
                    end
                    r.xfer_kind = kind;
                    r.xfer_byte = xb;
                    r.extra_clocks = waits;
                    if (dma_cur_cnt[ch] == 16'd0)
                    begin
                        if (md[4])
                        begin
                            dma_cur_addr[ch] = dma_base_addr[ch];
                            dma_cur_cnt[ch]  = dma_base_cnt[ch];
                        end
                        else
                        begin
                            dma_mask[ch] = 1'b1;
                            dma_cur_cnt[ch] = 16'hffff;
                        end
                        dma_hw_req[ch] = 1'b0;
                        dma_sw_req[ch] = 1'b0;
                        dma_tc[ch] = 1'b1;
                        dma_busy = 1'b0;
                        r.tc_pulse = 1'b1;
                    end
                    else
                    begin
                        dma_cur_cnt[ch] = dma_cur_cnt[ch] - 1'b1;
                        if (md[7:6] == 2'b01)
                            dma_busy = 1'b0;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // half register traffic that opens channels up, plus requests and ticks
    function automatic void pick_random_item(output cmd_t op, output in_item_t it);
        int roll;
        it = '0;
        it.reg_addr      = 4'($urandom);
        it.write_data    = 8'($urandom);
        it.req_channel   = 2'($urandom);
        it.request_level = 1'($urandom);
        it.transfer_byte = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 35)
            op = CMD_TICK;
        else if (roll < 50)
            op = CMD_REQ;
        else if (roll < 65)
            op = CMD_READ;
        else
        begin
            op = CMD_WRITE;
            case ($urandom_range(0, 19))
                0:
                begin
                    it.reg_addr = REG_CTRL;
                    it.write_data[0] = ($urandom_range(0, 3) == 0);
                end
                1, 2: it.reg_addr = REG_SELECT;
                3, 4:
                begin
                    it.reg_addr = REG_CNT_LO;
                    if ($urandom_range(0, 3) != 0)
                        it.write_data = 8'($urandom_range(0, 6));
                end
                5:
                begin
                    it.reg_addr = REG_CNT_HI;
                    if ($urandom_range(0, 3) != 0)
                        it.write_data = '0;
                end
                6:  it.reg_addr = REG_ADDR_0;
                7:  it.reg_addr = REG_ADDR_1;
                8:  it.reg_addr = REG_ADDR_2;
                9:
                begin
                    it.reg_addr = REG_CMD_LO;
                    it.write_data[2] = ($urandom_range(0, 5) == 0);
                end
                10: it.reg_addr = REG_CMD_HI;
                11, 12, 13: it.reg_addr = REG_MODE;
                14, 15: it.reg_addr = REG_SWREQ;
                16, 17:
                begin
                    it.reg_addr = REG_MASK;
                    if ($urandom_range(0, 1) == 0)
                        it.write_data = '0;
                end
                18:
                begin
                    case ($urandom_range(0, 3))
                        0: it.reg_addr = REG_GAP;
                        1: it.reg_addr = REG_STATUS;
                        2: it.reg_addr = REG_TEMP_LO;
                        default: it.reg_addr = REG_TEMP_HI;
                    endcase
                end
                default: ;
            endcase
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("result %0d %s: got %0h want %0h", results_seen, what, got, want);
    endtask

    task automatic offer_item(cmd_t op, in_item_t it);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= it;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_wanted && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : watch_results
        res_t got;
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (dma_results_due.size() == 0)
                report_mismatch("item with none due", 32'(got), 32'd0);
            else
            begin
                want = dma_results_due.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", 32'(got.read_data),
                                    32'(want.read_data));
                if (got.transfer_valid !== want.transfer_valid)
                    report_mismatch("transfer_valid", 32'(got.transfer_valid),
                                    32'(want.transfer_valid));
                if (got.xfer_channel !== want.xfer_channel)
                    report_mismatch("xfer_channel", 32'(got.xfer_channel),
                                    32'(want.xfer_channel));
                if (got.xfer_address !== want.xfer_address)
                    report_mismatch("xfer_address", 32'(got.xfer_address),
                                    32'(want.xfer_address));
                if (got.xfer_kind !== want.xfer_kind)
                    report_mismatch("xfer_kind", 32'(got.xfer_kind),
                                    32'(want.xfer_kind));
                if (got.xfer_byte !== want.xfer_byte)
                    report_mismatch("xfer_byte", 32'(got.xfer_byte),
                                    32'(want.xfer_byte));
                if (got.extra_clocks !== want.extra_clocks)
                    report_mismatch("extra_clocks", 32'(got.extra_clocks),
                                    32'(want.extra_clocks));
                if (got.tc_pulse !== want.tc_pulse)
                    report_mismatch("tc_pulse", 32'(got.tc_pulse),
                                    32'(want.tc_pulse));
            end
            results_seen++;
        end
    end

    initial
    begin
        int       k;
        cmd_t     op;
        in_item_t it;
        res_t     want;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        rst_n = 1'b0;
        hold_off_wanted = 1'b0;
        src_idle_pct = 28;
        sink_idle_pct = 88;
        for (k = 0; k < NUM_CHANNELS; k++)
        begin
            dma_base_addr[k] = '0;
            dma_cur_addr[k] = '0;
            dma_base_cnt[k] = '0;
            dma_cur_cnt[k] = '0;
        end
        dma_soft_clear();
        dma_hw_req = '0;
        dma_wide = 1'b0;
        dma_busy = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
        begin
            it = '0;
            it.reg_addr      = dir_rows[k].addr;
            it.write_data    = dir_rows[k].data;
            it.req_channel   = dir_rows[k].ch;
            it.request_level = dir_rows[k].lvl;
            it.transfer_byte = dir_rows[k].xb;
            offer_item(dir_rows[k].op, it);
            want = dma_step_result(dir_rows[k].op, it);
            if (dir_rows[k].typed)
            begin
                want = '0;
                want.read_data = dir_rows[k].rd;
            end
            dma_results_due.push_back(want);
        end

        for (k = 0; k < RAND_ITEMS; k++)
        begin
            if (k == 600)
            begin
                src_idle_pct = 88;
                sink_idle_pct = 28;
            end
            if (k == 1200)
            begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
                hold_off_wanted = 1'b1;
            end
            pick_random_item(op, it);
            offer_item(op, it);
            dma_results_due.push_back(dma_step_result(op, it));
        end
        s_axis_tvalid <= 1'b0;

        while (dma_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
